FILE: hw/rtl/safs_pkg.sv
// Shared types and constants for the sprite animation frame sequencer.
package safs_pkg;

  // Command codes carried on the input tuser.
  typedef enum logic [2:0] {
    FN_TICK       = 3'd0,
    FN_SET_ANIM   = 3'd1,
    FN_PLAY_ONCE  = 3'd2,
    FN_FREEZE     = 3'd3,
    FN_LOAD_HOLD  = 3'd4,
    FN_LOAD_COUNT = 3'd5
  } func_t;

  localparam int FUNC_W   = 3;
  localparam int ANIM_W   = 3;
  localparam int FARG_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int TIME_W   = 32;
  localparam int FRAME_W  = 6;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 16;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch command and start table reads
    logic commit;   // update state and load the output register
  } safs_cmd_t;

endpackage

FILE: hw/rtl/sprite_animation_frame_sequencer.sv
// Sprite animation frame sequencer: top level joining controller and datapath.
//
// Each command transfer yields exactly one result transfer. The transfer
// cycle reads the hold table and the count table through their registered
// read ports; the execute state then updates the state and loads the
// output register once the output is free. The output register lets the
// next command be taken while a result waits; a command finishes only once
// the previous result has been taken, so a stalled output holds the block
// after at most one further command. Count entries start at zero after
// reset (per-entry valid bits, no clearing pass); hold entries must be
// loaded before a tick reads them.
module sprite_animation_frame_sequencer
  import safs_pkg::*;
#(
  parameter int NUM_ANIMS  = 8,
  parameter int MAX_FRAMES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // tdata: anim_index[2:0], frame_arg[10:3], value[42:11], now_ms[74:43], zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // tuser: func[2:0]
  input  logic [FUNC_W-1:0]   s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // tdata: anim_now[2:0], frame_now[8:3], busy_res[9], looping[10], redraw[11], zero fill
  output logic [M_DATA_W-1:0] m_tdata
);

  safs_cmd_t cmd;

  safs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  safs_dp #(
    .NUM_ANIMS  (NUM_ANIMS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule

FILE: hw/rtl/safs_ctrl.sv
// Sequencing controller: input handshake, command timing and output valid.
module safs_ctrl
  import safs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output safs_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd.capture = (state == ST_IDLE) && s_tvalid;
    cmd.commit  = (state == ST_EXEC) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_EXEC;
          if (m_tready) m_tvalid <= 1'b0;
        end
        ST_EXEC: begin
          if (out_free) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/safs_dp.sv
// Datapath: sequencer state, hold and count tables, and the output register.
module safs_dp
  import safs_pkg::*;
#(
  parameter int NUM_ANIMS  = 8,
  parameter int MAX_FRAMES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  safs_cmd_t             cmd,
  input  logic [FUNC_W-1:0]     s_tuser,
  input  logic [S_DATA_W-1:0]   s_tdata,
  output logic [M_DATA_W-1:0]   m_tdata
);

  localparam int DEPTH = NUM_ANIMS * MAX_FRAMES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AIW   = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
  localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW    = $clog2(MAX_FRAMES + 1);
  localparam int CW1   = CW + 1;

  // Input fields
  logic [ANIM_W-1:0]         in_anim;
  func_t                     in_func;
  assign in_func = func_t'(s_tuser);
  assign in_anim = s_tdata[2:0];

  // Captured command
  func_t                     func_q;
  logic [ANIM_W-1:0]         anim_q;
  logic signed [FARG_W-1:0]  farg_q;
  logic [VALUE_W-1:0]        value_q;
  logic [TIME_W-1:0]         now_q;

  // Sequencer state
  logic [ANIM_W-1:0]         cur_anim;
  logic [FW-1:0]             cur_frame;
  logic [TIME_W-1:0]         start_time;
  logic                      loop_flag;
  logic                      busy_flag;

  logic [ANIM_W-1:0]         cur_anim_next;
  logic [FW-1:0]             cur_frame_next;
  logic [TIME_W-1:0]         start_time_next;
  logic                      loop_flag_next;
  logic                      busy_flag_next;
  logic                      redraw;

  // Tables
  logic [VALUE_W-1:0]        hold_mem [DEPTH];
  logic [CW-1:0]             cnt_mem  [NUM_ANIMS];
  logic [NUM_ANIMS-1:0]      cnt_vld;
  logic [VALUE_W-1:0]        hold_rd;
  logic [CW-1:0]             cnt_rd;
  logic                      cnt_rd_vld;

  logic [ANIM_W-1:0]         sel_anim;
  logic [AIW-1:0]            cnt_raddr;
  logic [AW-1:0]             hold_raddr;
  logic [AW-1:0]             hold_waddr;
  logic [AIW-1:0]            cnt_waddr;
  logic                      hold_we;
  logic                      cnt_we;
  logic [CW-1:0]             cnt_sat;

  logic [CW-1:0]             cnt;
  logic                      anim_ok;
  logic [TIME_W-1:0]         elapsed;
  logic [CW1-1:0]            frame_inc;
  logic [FW-1:0]             frz_frame;

  // Read addresses come from the incoming transfer and the current state.
  always_comb begin
    sel_anim   = (in_func == FN_FREEZE) ? in_anim : cur_anim;
    cnt_raddr  = (int'(sel_anim) < NUM_ANIMS) ? AIW'(sel_anim) : '0;
    hold_raddr = AW'(int'(cur_anim) * MAX_FRAMES + int'(cur_frame));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= in_func;
      anim_q     <= in_anim;
      farg_q     <= s_tdata[10:3];
      value_q    <= s_tdata[42:11];
      now_q      <= s_tdata[74:43];
      hold_rd    <= hold_mem[hold_raddr];
      cnt_rd     <= cnt_mem[cnt_raddr];
    end
    if (hold_we) hold_mem[hold_waddr] <= value_q;
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld    <= '0;
      cnt_rd_vld <= 1'b0;
    end else begin
      if (cmd.capture) cnt_rd_vld <= cnt_vld[cnt_raddr];
      if (cnt_we) cnt_vld[cnt_waddr] <= 1'b1;
    end
  end

  // Command execution
  always_comb begin
    anim_ok    = int'(anim_q) < NUM_ANIMS;
    cnt        = cnt_rd_vld ? cnt_rd : '0;
    elapsed    = now_q - start_time;
    frame_inc  = CW1'(cur_frame) + CW1'(1);
    hold_waddr = AW'(int'(anim_q) * MAX_FRAMES + int'(farg_q[6:0]));
    cnt_waddr  = AIW'(anim_q);
    cnt_sat    = (value_q > VALUE_W'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(value_q);

    if (farg_q[7] || cnt == '0) begin
      frz_frame = '0;
    end else if (int'(farg_q[6:0]) >= int'(cnt)) begin
      frz_frame = FW'(cnt - CW'(1));
    end else begin
      frz_frame = FW'(farg_q[6:0]);
    end

    cur_anim_next   = cur_anim;
    cur_frame_next  = cur_frame;
    start_time_next = start_time;
    loop_flag_next  = loop_flag;
    busy_flag_next  = busy_flag;
    redraw          = 1'b0;
    hold_we         = 1'b0;
    cnt_we          = 1'b0;

    case (func_q)
      FN_TICK: begin
        if (cnt != '0 && (loop_flag || busy_flag) && elapsed >= hold_rd) begin
          start_time_next = now_q;
          if (frame_inc >= {1'b0, cnt}) begin
            if (loop_flag) begin
              cur_frame_next = '0;
              redraw         = 1'b1;
            end else begin
              busy_flag_next = 1'b0;
            end
          end else begin
            cur_frame_next = FW'(frame_inc);
            redraw         = 1'b1;
          end
        end
      end
      FN_SET_ANIM: begin
        if (anim_ok) begin
          loop_flag_next = 1'b1;
          busy_flag_next = 1'b0;
          if (anim_q != cur_anim) begin
            cur_anim_next   = anim_q;
            cur_frame_next  = '0;
            start_time_next = now_q;
            redraw          = 1'b1;
          end
        end
      end
      FN_PLAY_ONCE: begin
        if (anim_ok) begin
          cur_anim_next   = anim_q;
          cur_frame_next  = '0;
          start_time_next = now_q;
          loop_flag_next  = 1'b0;
          busy_flag_next  = 1'b1;
          redraw          = 1'b1;
        end
      end
      FN_FREEZE: begin
        if (anim_ok) begin
          cur_anim_next   = anim_q;
          cur_frame_next  = frz_frame;
          start_time_next = now_q;
          loop_flag_next  = 1'b0;
          busy_flag_next  = 1'b0;
          redraw          = 1'b1;
        end
      end
      FN_LOAD_HOLD: begin
        hold_we = cmd.commit && anim_ok && !farg_q[7] &&
                  (int'(farg_q[6:0]) < MAX_FRAMES);
      end
      FN_LOAD_COUNT: begin
        cnt_we = cmd.commit && anim_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_anim   <= '0;
      cur_frame  <= '0;
      start_time <= '0;
      loop_flag  <= 1'b1;
      busy_flag  <= 1'b0;
    end else if (cmd.commit) begin
      cur_anim   <= cur_anim_next;
      cur_frame  <= cur_frame_next;
      start_time <= start_time_next;
      loop_flag  <= loop_flag_next;
      busy_flag  <= busy_flag_next;
    end
  end

  // Output register; bits above redraw are zero fill.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {4'b0, redraw, loop_flag_next, busy_flag_next,
                  FRAME_W'(cur_frame_next), cur_anim_next};
    end
  end

endmodule
